FILE: rtl/ssbr_pkg.sv
// ----------------------------------------------------------------------------
// Slow serial receiver package
// Types and fixed constants shared by the receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssbr_pkg;

    localparam int ELAPSED_WIDTH = 16;
    localparam int BYTE_WIDTH    = 8;
    localparam int COUNT_WIDTH   = 4;

    // Number of data bits in one frame.
    localparam logic [COUNT_WIDTH-1:0] DATA_BITS = 4'd8;

    // Bit period after reset, in microseconds.
    localparam int RESET_PERIOD = 10000;

    typedef struct packed {
        logic [ELAPSED_WIDTH-1:0] elapsed_us;
        logic                     rx_level;
    } t_poll;

    typedef struct packed {
        logic                  emit;
        logic [BYTE_WIDTH-1:0] data;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ssbr_frame_ctl.sv
// ----------------------------------------------------------------------------
// Slow serial receiver frame control
// Holds the countdown, bit counter and assembly byte, and processes one
// registered poll per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssbr_frame_ctl #(
    parameter int PERIOD_WIDTH = 20
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [PERIOD_WIDTH-1:0] i_period,
    input  wire logic                    i_step,
    input  wire ssbr_pkg::t_poll         i_poll,
    output ssbr_pkg::t_result            o_result
);

    localparam int TW = PERIOD_WIDTH + 4;
    localparam int DW = ((PERIOD_WIDTH + 2 > ssbr_pkg::ELAPSED_WIDTH) ?
                         PERIOD_WIDTH + 2 : ssbr_pkg::ELAPSED_WIDTH) + 2;

    logic                             r_receiving;
    logic [ssbr_pkg::COUNT_WIDTH-1:0] r_bit_count;
    logic signed [TW-1:0]             r_tts;
    logic [ssbr_pkg::BYTE_WIDTH-1:0]  r_shift;

    logic                             n_receiving;
    logic [ssbr_pkg::COUNT_WIDTH-1:0] n_bit_count;
    logic signed [TW-1:0]             n_tts;
    logic [ssbr_pkg::BYTE_WIDTH-1:0]  n_shift;
    logic                             n_emit;

    logic signed [DW-1:0] w_p;
    logic signed [DW-1:0] w_t;
    logic signed [DW-1:0] w_el;
    logic signed [DW-1:0] w_diff;
    logic signed [DW-1:0] w_neg2p;
    logic signed [DW-1:0] w_floor;
    logic signed [DW-1:0] w_sat;
    logic                 w_drop;

    assign w_p     = $signed({{(DW - PERIOD_WIDTH){1'b0}}, i_period});
    assign w_t     = DW'(r_tts);
    assign w_el    = $signed({{(DW - ssbr_pkg::ELAPSED_WIDTH){1'b0}}, i_poll.elapsed_us});
    assign w_diff  = w_t - w_el;
    assign w_neg2p = -(w_p <<< 1);
    assign w_floor = w_neg2p - DW'(1);
    assign w_drop  = w_diff < w_neg2p;
    assign w_sat   = w_drop ? w_floor : w_diff;

    always_comb begin
        n_receiving = r_receiving && !w_drop;
        n_bit_count = r_bit_count;
        n_tts       = TW'(w_sat);
        n_shift     = r_shift;
        n_emit      = 1'b0;
        if (!n_receiving) begin
            n_shift = '0;
            if (i_poll.rx_level) begin
                n_receiving = 1'b1;
                n_bit_count = '0;
                n_tts       = TW'(w_p + (w_p >>> 2));
            end
        end else if (w_sat[DW-1]) begin
            if (r_bit_count < ssbr_pkg::DATA_BITS) begin
                if (!i_poll.rx_level) begin
                    n_shift[r_bit_count[2:0]] = 1'b1;
                end
                n_tts       = TW'(w_sat + w_p);
                n_bit_count = r_bit_count + 4'd1;
            end else begin
                n_receiving = 1'b0;
                n_emit      = 1'b1;
            end
        end
    end

    assign o_result.emit = n_emit;
    assign o_result.data = r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_bit_count <= '0;
            r_tts       <= '0;
            r_shift     <= '0;
        end else if (i_step) begin
            r_receiving <= n_receiving;
            r_bit_count <= n_bit_count;
            r_tts       <= n_tts;
            r_shift     <= n_shift;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= ssbr_pkg::DATA_BITS)
        else $error("bit counter beyond frame length");

    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.emit |-> (r_receiving && r_bit_count == ssbr_pkg::DATA_BITS))
        else $error("byte emitted before all data bits were sampled");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.emit) |=> !r_receiving)
        else $error("receiver still busy after emitting a byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/slow_serial_bit_receiver.sv
// ----------------------------------------------------------------------------
// Slow serial receiver
// Receives 8-bit frames on an inverted, polled serial line: a high level
// starts a frame, data bits are sampled least significant first with a low
// level read as one, and the stop level is not checked. Each request is one
// poll carrying the microseconds since the previous poll and the line level.
// One poll is accepted every clock cycle unless a held result stalls the input;
// a poll passes through an input register and the frame logic into the result
// register. The bit period is written through the configuration port; the user
// must write it only while the receiver is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slow_serial_bit_receiver #(
    parameter int PERIOD_WIDTH = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [PERIOD_WIDTH-1:0]             i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [ssbr_pkg::ELAPSED_WIDTH-1:0]  i_elapsed_us,
    input  wire logic                                i_rx_level,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [ssbr_pkg::BYTE_WIDTH-1:0]          o_received_byte
);

    localparam logic [PERIOD_WIDTH-1:0] RESET_PERIOD =
        PERIOD_WIDTH'(ssbr_pkg::RESET_PERIOD % (2 ** PERIOD_WIDTH));

    logic [PERIOD_WIDTH-1:0]         r_period;
    logic                            r_in_valid;
    ssbr_pkg::t_poll                 r_poll;
    logic                            r_out_valid;
    logic [ssbr_pkg::BYTE_WIDTH-1:0] r_out_byte;

    logic              w_out_free;
    logic              w_step;
    ssbr_pkg::t_result w_result;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_poll.elapsed_us <= i_elapsed_us;
            r_poll.rx_level   <= i_rx_level;
        end
    end

    ssbr_frame_ctl #(
        .PERIOD_WIDTH(PERIOD_WIDTH)
    ) u_frame_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_period),
        .i_step   (w_step),
        .i_poll   (r_poll),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.emit) begin
            r_out_byte <= w_result.data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_received_byte = r_out_byte;

`ifndef SYNTHESIS
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result produced without a registered poll");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_step)
        else $error("frame logic stepped while the result was stalled");

    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_poll)))
        else $error("registered poll lost during a stall");
`endif

endmodule

`default_nettype wire
